/* hdl/gbn_pkg.sv */
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants of the Go-Back-N transmit controller.
// ----------------------------------------------------------------------------
package gbn_pkg;

	localparam int MAX_WINDOW = 7;

	localparam int SEQ_W   = 3;
	localparam int IDX_W   = 16;
	localparam int RETRY_W = 8;
	localparam int WIN_W   = 3;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [WIN_W-1:0]   WINDOW_RESET = 3'd3;
	localparam logic [IDX_W-1:0]   COUNT_RESET  = 16'd5;
	localparam logic [RETRY_W-1:0] RETRY_RESET  = 8'd5;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_COUNT  = 2'd1;
	localparam logic [1:0] REG_RETRY  = 2'd2;

	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_ACK     = 2'd1,
		CMD_TIMEOUT = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_SEND = 2'd0,
		KIND_WAIT = 2'd1,
		KIND_DONE = 2'd2,
		KIND_FAIL = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SEND,
		ST_STAT
	} state_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [SEQ_W-1:0] ack_seq;
	} ev_word_t;

	typedef struct packed {
		kind_t            kind;
		logic [SEQ_W-1:0] seq_out;
		logic [IDX_W-1:0] payload;
		logic             last;
	} res_word_t;

	typedef struct packed {
		logic [WIN_W-1:0]   win_size;
		logic [IDX_W-1:0]   packet_count;
		logic [RETRY_W-1:0] retry_limit;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch_in;
		logic do_start;
		logic do_advance;
		logic do_fail;
		logic do_rewind;
		logic do_give_up;
		logic load_pkt;
		logic pkt_last;
		logic load_status;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic ack_match;
		logic retry_hit;
		logic gave_up;
		logic done;
		logic can_send;
		logic can_after;
	} dp_sts_t;

endpackage

/* hdl/gbn_cfg.sv */
// ----------------------------------------------------------------------------
// gbn_cfg
// APB-style register file holding window size, packet count and retry limit.
// ----------------------------------------------------------------------------
module gbn_cfg
	import gbn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_size     <= WINDOW_RESET;
			cfg_q.packet_count <= COUNT_RESET;
			cfg_q.retry_limit  <= RETRY_RESET;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_WINDOW: cfg_q.win_size     <= pwdata[WIN_W-1:0];
				REG_COUNT:  cfg_q.packet_count <= pwdata[IDX_W-1:0];
				REG_RETRY:  cfg_q.retry_limit  <= pwdata[RETRY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WINDOW: prdata = {{(DATA_W-WIN_W){1'b0}}, cfg_q.win_size};
			REG_COUNT:  prdata = {{(DATA_W-IDX_W){1'b0}}, cfg_q.packet_count};
			REG_RETRY:  prdata = {{(DATA_W-RETRY_W){1'b0}}, cfg_q.retry_limit};
			default:    prdata = '0;
		endcase
	end

endmodule

/* hdl/gbn_ctrl.sv */
// ----------------------------------------------------------------------------
// gbn_ctrl
// Event sequencer: takes one event, decides the state update, then emits its
// packet words or single status word one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module gbn_ctrl
	import gbn_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      ev_valid,
	output logic      ev_stall,
	output logic      res_valid,
	input  logic      res_stall,
	input  dp_sts_t   sts,
	output ctrl_cmd_t cmd
);

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   slot_free;

	assign slot_free = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_pkt || cmd.load_status) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		ev_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				ev_stall = 1'b0;
				if (ev_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (sts.cmd) inside
					CMD_START: begin
						cmd.do_start = 1'b1;
						state_d      = ST_SEND;
					end
					CMD_ACK, CMD_TIMEOUT: begin
						if (sts.gave_up || sts.done) begin
							state_d = ST_STAT;
						end else if (sts.cmd == CMD_ACK && sts.ack_match) begin
							cmd.do_advance = 1'b1;
							state_d        = ST_SEND;
						end else if (sts.retry_hit) begin
							cmd.do_fail    = 1'b1;
							cmd.do_give_up = 1'b1;
							state_d        = ST_STAT;
						end else begin
							cmd.do_fail   = 1'b1;
							cmd.do_rewind = 1'b1;
							state_d       = ST_SEND;
						end
					end
					CMD_NONE: begin
						state_d = ST_STAT;
					end
					default: state_d = ST_STAT;
				endcase
			end
			ST_SEND: begin
				if (slot_free) begin
					if (sts.can_send) begin
						cmd.load_pkt = 1'b1;
						cmd.pkt_last = !sts.can_after;
						if (!sts.can_after) begin
							state_d = ST_IDLE;
						end
					end else begin
						// Nothing fits in the window: one status word instead.
						cmd.load_status = 1'b1;
						state_d         = ST_IDLE;
					end
				end
			end
			ST_STAT: begin
				if (slot_free) begin
					cmd.load_status = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |=> state_q != ST_EXEC)
		else $error("evaluation state held for more than one cycle");

	a_last_ends_event: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_pkt && cmd.pkt_last) |=> state_q == ST_IDLE)
		else $error("final packet word did not close the event");

	a_start_sends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && sts.cmd == CMD_START) |=> state_q == ST_SEND)
		else $error("start event did not enter the send phase");

endmodule

/* hdl/gbn_dp.sv */
// ----------------------------------------------------------------------------
// gbn_dp
// Window datapath: base and send indexes, sequence counters, retry count and
// the registered result word.
// ----------------------------------------------------------------------------
module gbn_dp
	import gbn_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  ev_word_t  ev_data,
	input  cfg_t      cfg,
	input  ctrl_cmd_t cmd,
	output dp_sts_t   sts,
	output res_word_t res_data
);

	cmd_t               ev_cmd_q;
	logic [SEQ_W-1:0]   ev_ack_q;
	logic [IDX_W-1:0]   window_base_q;
	logic [IDX_W-1:0]   next_index_q;
	logic [SEQ_W-1:0]   base_seq_q;
	logic [SEQ_W-1:0]   send_seq_q;
	logic [RETRY_W-1:0] retry_count_q;
	logic               gave_up_q;
	res_word_t          res_q;

	logic [WIN_W-1:0]   eff_w;
	logic [RETRY_W-1:0] retry_inc;
	logic [IDX_W:0]     win_end;
	logic [IDX_W:0]     next_ext;
	logic [IDX_W:0]     next_inc;
	logic [IDX_W:0]     count_ext;
	kind_t              status_kind;

	function automatic logic [SEQ_W-1:0] seq_advance(logic [SEQ_W-1:0] s,
		logic [WIN_W-1:0] w);
		logic [SEQ_W-1:0] r;
		if (s >= w) begin
			r = '0;
		end else begin
			r = s + 1'b1;
		end
		return r;
	endfunction

	// A window of zero acts as one; anything above the maximum is clamped.
	always_comb begin
		eff_w = cfg.win_size;
		if (cfg.win_size == '0) begin
			eff_w = WIN_W'(1);
		end else if (int'(cfg.win_size) > MAX_WINDOW) begin
			eff_w = WIN_W'(MAX_WINDOW);
		end
	end

	assign retry_inc = (retry_count_q == '1) ? retry_count_q : retry_count_q + 1'b1;
	assign win_end   = {1'b0, window_base_q} + (IDX_W+1)'(eff_w);
	assign next_ext  = {1'b0, next_index_q};
	assign next_inc  = next_ext + 1'b1;
	assign count_ext = {1'b0, cfg.packet_count};

	always_comb begin
		if (gave_up_q) begin
			status_kind = KIND_FAIL;
		end else if (window_base_q >= cfg.packet_count) begin
			status_kind = KIND_DONE;
		end else begin
			status_kind = KIND_WAIT;
		end
	end

	assign sts.cmd       = ev_cmd_q;
	assign sts.ack_match = (ev_ack_q == base_seq_q) && (window_base_q != next_index_q);
	assign sts.retry_hit = retry_inc >= cfg.retry_limit;
	assign sts.gave_up   = gave_up_q;
	assign sts.done      = window_base_q >= cfg.packet_count;
	assign sts.can_send  = (next_ext < win_end) && (next_ext < count_ext);
	assign sts.can_after = (next_inc < win_end) && (next_inc < count_ext);

	assign res_data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_base_q <= '0;
			next_index_q  <= '0;
			base_seq_q    <= '0;
			send_seq_q    <= '0;
			retry_count_q <= '0;
			gave_up_q     <= 1'b0;
		end else begin
			if (cmd.do_start) begin
				window_base_q <= '0;
				next_index_q  <= '0;
				base_seq_q    <= '0;
				send_seq_q    <= '0;
				retry_count_q <= '0;
				gave_up_q     <= 1'b0;
			end
			if (cmd.do_advance) begin
				retry_count_q <= '0;
				window_base_q <= window_base_q + 1'b1;
				base_seq_q    <= seq_advance(base_seq_q, eff_w);
			end
			if (cmd.do_fail) begin
				retry_count_q <= retry_inc;
			end
			if (cmd.do_give_up) begin
				gave_up_q <= 1'b1;
			end
			if (cmd.do_rewind) begin
				next_index_q <= window_base_q;
				send_seq_q   <= base_seq_q;
			end
			if (cmd.load_pkt) begin
				next_index_q <= next_index_q + 1'b1;
				send_seq_q   <= seq_advance(send_seq_q, eff_w);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			ev_cmd_q <= ev_data.cmd;
			ev_ack_q <= ev_data.ack_seq;
		end
		if (cmd.load_pkt) begin
			res_q.kind    <= KIND_SEND;
			res_q.seq_out <= send_seq_q;
			res_q.payload <= next_index_q + 1'b1;
			res_q.last    <= cmd.pkt_last;
		end else if (cmd.load_status) begin
			res_q.kind    <= status_kind;
			res_q.seq_out <= '0;
			res_q.payload <= '0;
			res_q.last    <= 1'b1;
		end
	end

	a_base_not_past_next: assert property (@(posedge clk) disable iff (!arst_n)
		window_base_q <= next_index_q)
		else $error("window base moved past the send index");

endmodule

/* hdl/go_back_n_sender.sv */
// ----------------------------------------------------------------------------
// go_back_n_sender
// Go-Back-N transmit controller.
//
// Events (start, ack with ack_seq, timeout, none) enter on the ev channel; the
// block answers each one on the res channel with every packet word the window
// now allows (kind send, seq_out, payload = index + 1), or with one status
// word (waiting, done, gave up). The last word of each event has last set.
// An event is accepted, evaluated in the next cycle, and then one word is
// loaded per cycle into the output register while the receiver does not
// stall. The words come from the sequencer through a single output register.
// When the receiver stalls, the output register holds its word and the
// sequencer waits; a new event is taken as soon as the previous event's last
// word sits in the output register. Reset clears window state, retry count
// and the give-up flag, and loads the registers with window 3, packet count
// 5 and retry limit 5. The user must write registers through the APB-style
// port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module go_back_n_sender
	import gbn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ev_valid,
	output logic              ev_stall,
	input  ev_word_t          ev_data,
	output logic              res_valid,
	input  logic              res_stall,
	output res_word_t         res_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t      cfg;
	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	assign pready = 1'b1;

	gbn_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	gbn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (ev_valid),
		.ev_stall  (ev_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	gbn_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_data  (ev_data),
		.cfg      (cfg),
		.cmd      (cmd),
		.sts      (sts),
		.res_data (res_data)
	);

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Go-Back-N transmit controller. A short directed
// run covers the corner cases and the register extremes. It is followed by
// random phases with fresh register settings: mostly in-order acks with some
// timeouts, wrong acks and restarts. Every accepted event is run through a
// local model of the sender. Each result word is compared field by field with
// the oldest predicted word.
// ----------------------------------------------------------------------------
module testbench;
	import gbn_pkg::*;

	localparam int IDLE_PCT    = 7;
	localparam int WATCHDOG    = 2000;
	localparam int PHASES      = 8;
	localparam int PHASE_EVENTS = 42;
	localparam int HOLD_CYCLES = 80;

	logic              clk;
	logic              arst_n;
	logic              ev_valid;
	logic              ev_stall;
	ev_word_t          ev_data;
	logic              res_valid;
	logic              res_stall;
	res_word_t         res_data;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// Register copies and window state of the local sender model.
	logic [WIN_W-1:0]   sh_window = WINDOW_RESET;
	logic [IDX_W-1:0]   sh_count  = COUNT_RESET;
	logic [RETRY_W-1:0] sh_retry  = RETRY_RESET;
	logic [IDX_W-1:0]   win_base  = '0;
	logic [IDX_W-1:0]   next_idx  = '0;
	logic [SEQ_W-1:0]   base_seq  = '0;
	logic [SEQ_W-1:0]   send_seq  = '0;
	logic [RETRY_W-1:0] retries   = '0;
	logic               gave_up   = 1'b0;

	ev_word_t  event_queue[$];
	res_word_t due_words[$];
	int        events_posted = 0;
	int        events_taken  = 0;
	int        errors        = 0;
	int        quiet         = 0;
	int        hold_left     = 0;
	logic      held          = 1'b0;
	logic      hold_req      = 1'b0;
	logic      calm          = 1'b0;

	go_back_n_sender u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (ev_valid),
		.ev_stall  (ev_stall),
		.ev_data   (ev_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	function automatic int eff_window();
		int w;
		w = int'(sh_window);
		if (w == 0) w = 1;
		if (w > MAX_WINDOW) w = MAX_WINDOW;
		return w;
	endfunction

	// Sequence counters wrap on the advance after they reach the window.
	function automatic logic [SEQ_W-1:0] seq_step(input logic [SEQ_W-1:0] s);
		if (int'(s) >= eff_window()) return '0;
		return s + 1'b1;
	endfunction

	function automatic void push_status();
		res_word_t w;
		w = '0;
		if (gave_up) w.kind = KIND_FAIL;
		else if (win_base >= sh_count) w.kind = KIND_DONE;
		else w.kind = KIND_WAIT;
		w.last = 1'b1;
		due_words.push_back(w);
	endfunction

	function automatic void push_window();
		int stop;
		int n;
		int i;
		res_word_t w;
		if (win_base >= sh_count) begin
			push_status();
			return;
		end
		stop = int'(win_base) + eff_window();
		if (stop > int'(sh_count)) stop = int'(sh_count);
		n = stop - int'(next_idx);
		if (n <= 0) begin
			push_status();
			return;
		end
		for (i = 0; i < n; i++) begin
			w.kind    = KIND_SEND;
			w.seq_out = send_seq;
			w.payload = next_idx + 1'b1;
			w.last    = (i == n - 1);
			due_words.push_back(w);
			next_idx = next_idx + 1'b1;
			send_seq = seq_step(send_seq);
		end
	endfunction

	function automatic void push_failure();
		if (retries != 8'hFF) retries = retries + 1'b1;
		if (retries >= sh_retry) begin
			gave_up = 1'b1;
			push_status();
		end else begin
			next_idx = win_base;
			send_seq = base_seq;
			push_window();
		end
	endfunction

	function automatic void predict_words(input ev_word_t ev);
		if (ev.cmd == CMD_START) begin
			win_base = '0;
			next_idx = '0;
			base_seq = '0;
			send_seq = '0;
			retries  = '0;
			gave_up  = 1'b0;
			push_window();
		end else if (ev.cmd == CMD_NONE || gave_up || win_base >= sh_count) begin
			push_status();
		end else if (ev.cmd == CMD_TIMEOUT) begin
			push_failure();
		end else if (ev.ack_seq == base_seq && win_base != next_idx) begin
			retries  = '0;
			win_base = win_base + 1'b1;
			base_seq = seq_step(base_seq);
			push_window();
		end else begin
			push_failure();
		end
	endfunction

	task automatic post(input cmd_t c, input int ack);
		ev_word_t e;
		e.cmd     = c;
		e.ack_seq = ack[SEQ_W-1:0];
		event_queue.push_back(e);
		events_posted++;
	endtask

	// Waits until every event is taken and every predicted word has arrived.
	task automatic settle();
		do @(negedge clk);
		while (event_queue.size() != 0 || events_taken != events_posted ||
			due_words.size() != 0);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_WINDOW: sh_window = val[WIN_W-1:0];
			REG_COUNT:  sh_count  = val[IDX_W-1:0];
			default:    sh_retry  = val[RETRY_W-1:0];
		endcase
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Event driver: a new word is offered only once the current one is taken.
	always @(posedge clk) begin
		if (!ev_valid || !ev_stall) begin
			if (event_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				ev_valid <= 1'b1;
				ev_data  <= event_queue.pop_front();
			end else begin
				ev_valid <= 1'b0;
			end
		end
	end

	// Result receiver, with one long hold-off on request.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else if (hold_req && !held) begin
			held      <= 1'b1;
			hold_left <= HOLD_CYCLES;
			res_stall <= 1'b1;
		end else begin
			res_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin : monitor
		res_word_t want;
		if (ev_valid && !ev_stall) begin
			predict_words(ev_data);
			events_taken++;
		end
		if (res_valid && !res_stall) begin
			if (due_words.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: kind=%0d seq=%0d payload=%0d last=%0d",
						res_data.kind, res_data.seq_out, res_data.payload, res_data.last);
			end else begin
				want = due_words.pop_front();
				if (res_data.kind !== want.kind || res_data.seq_out !== want.seq_out ||
					res_data.payload !== want.payload || res_data.last !== want.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected kind=%0d seq=%0d payload=%0d last=%0d, %s",
							want.kind, want.seq_out, want.payload, want.last,
							$sformatf("got kind=%0d seq=%0d payload=%0d last=%0d",
							res_data.kind, res_data.seq_out, res_data.payload,
							res_data.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((ev_valid && !ev_stall) || (res_valid && !res_stall) || (psel && penable)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG) begin
			$display("testbench: errors");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin : sequencer
		int   ph;
		int   r;
		int   ack;
		int   val;
		int   counted;
		cmd_t c;
		arst_n    = 1'b0;
		ev_valid  = 1'b0;
		ev_data   = '0;
		res_stall = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: window 3, five packets, retry limit 5.
		post(CMD_ACK, 0);       // ack with nothing outstanding
		post(CMD_NONE, 7);
		post(CMD_START, 0);
		post(CMD_ACK, 0);
		post(CMD_ACK, 1);
		post(CMD_ACK, 5);       // wrong ack rewinds to the base
		post(CMD_TIMEOUT, 0);
		post(CMD_ACK, 2);
		post(CMD_ACK, 3);
		post(CMD_ACK, 0);       // last packet acknowledged
		post(CMD_ACK, 0);       // ack after done
		settle();

		// A window of zero acts as one; a retry limit of zero gives up at once.
		write_reg(REG_WINDOW, 0);
		write_reg(REG_COUNT, 2);
		write_reg(REG_RETRY, 0);
		post(CMD_START, 0);
		post(CMD_TIMEOUT, 0);
		post(CMD_ACK, 0);       // event after give-up
		post(CMD_START, 0);
		post(CMD_ACK, 0);
		settle();

		write_reg(REG_WINDOW, 7);
		write_reg(REG_COUNT, 16'hFFFF);
		write_reg(REG_RETRY, 8'hFF);
		post(CMD_START, 0);
		for (ack = 0; ack < 8; ack++) post(CMD_ACK, ack);
		settle();

		write_reg(REG_COUNT, 0);
		post(CMD_START, 0);

		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			calm = (ph == 3);
			write_reg(REG_WINDOW, $urandom_range(7));
			r = $urandom_range(9);
			if (r == 0) val = 16'hFFFF;
			else if (r == 1) val = $urandom_range(16'hFFFF);
			else val = $urandom_range(24, 1);
			write_reg(REG_COUNT, val);
			r = $urandom_range(9);
			if (r == 0) val = 8'hFF;
			else if (r == 1) val = 0;
			else val = $urandom_range(6, 1);
			write_reg(REG_RETRY, val);
			counted = 0;
			while (counted < PHASE_EVENTS) begin
				do @(negedge clk);
				while (events_taken != events_posted);
				if (ph == 1 && counted == 20) hold_req = 1'b1;
				r   = $urandom_range(99);
				ack = $urandom_range(7);
				if (r < 3) begin
					c = CMD_NONE;
				end else if (r < 6 || ((gave_up || win_base >= sh_count) && r < 70)) begin
					c = CMD_START;
				end else if (r < 16) begin
					c = CMD_TIMEOUT;
				end else begin
					c = CMD_ACK;
					if (r < 85) ack = int'(base_seq);
				end
				if (c == CMD_START || (c != CMD_NONE && !gave_up && win_base < sh_count))
					counted++;
				post(c, ack);
			end
		end
		settle();

		if (errors == 0 && due_words.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
